// ===== hdl/charge_accumulator_track_centroid_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef CHARGE_ACCUMULATOR_TRACK_CENTROID_MACROS_SVH
`define CHARGE_ACCUMULATOR_TRACK_CENTROID_MACROS_SVH

// condition holds at every edge
`define CHACC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define CHACC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHACC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/chacc_pkg.sv =====
// ----------------------------------------------------------------------------
// chacc_pkg
// Field widths, defaults and shared types of the charge accumulator.
// ----------------------------------------------------------------------------
package chacc_pkg;

  localparam int NUM_BINS_DEF = 512;
  localparam int NUM_TAGS_DEF = 16;

  localparam int BIN_W  = 9;
  localparam int CHG_W  = 16;
  localparam int ID_W   = 16;
  localparam int TOT_W  = 32;
  localparam int WGT_W  = 32;
  localparam int MEAN_W = 17;
  localparam int SLOT_W = 4;
  localparam int FRAC_W = 8;

  // weighted mean divide: w*m + c*(b<<8) over w + c
  localparam int NUM_W = WGT_W + MEAN_W + 1;
  localparam int DEN_W = WGT_W + 1;
  localparam int QUO_W = MEAN_W;

  typedef enum logic {
    OP_FILL  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [WGT_W-1:0]  weight;
    logic [MEAN_W-1:0] mean;
  } tag_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== hdl/chacc_ram.sv =====
// ----------------------------------------------------------------------------
// chacc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chacc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/chacc_div.sv =====
// ----------------------------------------------------------------------------
// chacc_div
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W.
// ----------------------------------------------------------------------------
module chacc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [chacc_pkg::NUM_W-1:0] num,
  input  logic [chacc_pkg::DEN_W-1:0] den,
  output logic [chacc_pkg::QUO_W-1:0] quo,
  output chacc_pkg::div_sts_t         sts
);
  import chacc_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [NUM_W:0]   diff;

  assign diff = {1'b0, rem} - {1'b0, dsh};
  assign sts  = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= NUM_W'(den) << (QUO_W - 1);
        quo  <= '0;
        cnt  <= CNT_W'(QUO_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[NUM_W]) begin
          rem <= diff[NUM_W-1:0];
        end
        quo <= {quo[QUO_W-2:0], !diff[NUM_W]};
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/charge_accumulator_track_centroid.sv =====
// ----------------------------------------------------------------------------
// charge_accumulator_track_centroid
// Saturating per-bin charge store with a track tag table and weighted mean.
// ----------------------------------------------------------------------------
//  channel | ports                                   | transaction
//  fill    | fill_valid/fill_ready, op..track_id     | one fill or clear item
//  result  | res_valid/res_ready, bin_total..mean    | one result per item
//
//  Fill without tag: S_BRD, S_BADD, S_OUT; with tag, new or dropped, S_SRCH over the slots.
//  Known tag: S_SRCH to its slot, S_MUL, S_DIVS, the 17-step divider if w + c is nonzero, S_TWR.
//  Tag search reads one table entry per cycle from the tag RAM.
//  After reset and after a clear item the bin RAM is swept with fill_ready low.
//  A pending result stalls the next item only at its end.
// ----------------------------------------------------------------------------
`include "charge_accumulator_track_centroid_macros.svh"

module charge_accumulator_track_centroid #(
  parameter int NUM_BINS = chacc_pkg::NUM_BINS_DEF,
  parameter int NUM_TAGS = chacc_pkg::NUM_TAGS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fill_valid,
  output logic                         fill_ready,
  input  logic                         op,
  input  logic [chacc_pkg::BIN_W-1:0]  time_bin,
  input  logic [chacc_pkg::CHG_W-1:0]  charge,
  input  logic                         has_track,
  input  logic [chacc_pkg::ID_W-1:0]   track_id,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [chacc_pkg::TOT_W-1:0]  bin_total,
  output logic [chacc_pkg::SLOT_W-1:0] slot,
  output logic                         new_entry,
  output logic                         table_full,
  output logic [chacc_pkg::WGT_W-1:0]  track_weight,
  output logic [chacc_pkg::MEAN_W-1:0] track_mean_bin
);
  import chacc_pkg::*;

  localparam int BIN_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int TAG_AW = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
  localparam int CNT_W  = $clog2(NUM_TAGS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_BRD, S_BADD, S_SRCH, S_MUL, S_DIVS, S_DIVW, S_TWR, S_OUT
  } state_t;

  state_t                    state;
  logic [BIN_AW-1:0]         clr_idx;
  logic                      active_flag;
  logic [CNT_W-1:0]          tag_count;
  op_t                       op_q;
  logic [BIN_W-1:0]          bin_q;
  logic [CHG_W-1:0]          chg_q;
  logic                      trk_q;
  logic [ID_W-1:0]           id_q;
  logic [CNT_W-1:0]          sidx;
  logic [TAG_AW-1:0]         cmp_idx;
  logic                      cmp_vld;
  logic [TAG_AW-1:0]         hit_idx;
  logic [WGT_W-1:0]          w_q;
  logic [MEAN_W-1:0]         m_q;
  logic [WGT_W+MEAN_W-1:0]   prod_wm;
  logic [CHG_W+BIN_W-1:0]    prod_cb;
  logic [DEN_W-1:0]          wsum;
  logic [TOT_W-1:0]          r_total;
  logic [SLOT_W-1:0]         r_slot;
  logic                      r_new;
  logic                      r_full;
  logic [WGT_W-1:0]          r_weight;
  logic [MEAN_W-1:0]         r_mean;

  logic [BIN_AW-1:0]         bin_addr;
  logic                      bin_ok;
  logic [TOT_W:0]            bin_sum;
  logic [TOT_W-1:0]          bin_sat;
  logic                      bin_we;
  logic [BIN_AW-1:0]         bin_waddr;
  logic [TOT_W-1:0]          bin_wdata;
  logic [TOT_W-1:0]          bin_rdata;

  tag_entry_t                tag_rd;
  tag_entry_t                tag_wdata;
  logic                      tag_we;
  logic [TAG_AW-1:0]         tag_waddr;
  logic                      hit;
  logic                      miss;
  logic                      room;
  logic [MEAN_W-1:0]         mean_ins;
  logic [WGT_W-1:0]          wsat;

  logic [NUM_W-1:0]          div_num;
  logic                      div_start;
  logic [QUO_W-1:0]          div_quo;
  div_sts_t                  div_sts;

  logic                      clr_acc;

  assign fill_ready = (state == S_IDLE);

  always_comb begin
    bin_addr  = BIN_AW'(bin_q);
    bin_ok    = 32'(bin_q) < NUM_BINS;
    bin_sum   = {1'b0, bin_rdata} + (TOT_W+1)'(chg_q);
    bin_sat   = bin_sum[TOT_W] ? '1 : bin_sum[TOT_W-1:0];
    bin_we    = (state == S_CLR) || ((state == S_BADD) && bin_ok);
    bin_waddr = (state == S_CLR) ? clr_idx : bin_addr;
    bin_wdata = (state == S_CLR) ? '0 : bin_sat;

    hit       = cmp_vld && (tag_rd.id == id_q);
    miss      = !cmp_vld && (sidx >= tag_count);
    room      = tag_count < CNT_W'(NUM_TAGS);
    mean_ins  = MEAN_W'({bin_q, FRAC_W'(0)});
    wsat      = wsum[WGT_W] ? '1 : wsum[WGT_W-1:0];

    tag_we    = ((state == S_SRCH) && !hit && miss && room) || (state == S_TWR);
    tag_waddr = (state == S_TWR) ? hit_idx : tag_count[TAG_AW-1:0];
    if (state == S_TWR) begin
      tag_wdata = '{id: id_q, weight: wsat, mean: m_q};
    end else begin
      tag_wdata = '{id: id_q, weight: WGT_W'(chg_q), mean: mean_ins};
    end

    div_num   = NUM_W'(prod_wm) + (NUM_W'(prod_cb) << FRAC_W);
    div_start = (state == S_DIVS) && (wsum != '0);

    clr_acc   = fill_valid && fill_ready && (op_t'(op) == OP_CLEAR);
  end

  chacc_ram #(
    .WIDTH (TOT_W),
    .DEPTH (NUM_BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_addr),
    .rdata (bin_rdata)
  );

  chacc_ram #(
    .WIDTH ($bits(tag_entry_t)),
    .DEPTH (NUM_TAGS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (sidx[TAG_AW-1:0]),
    .rdata (tag_rd)
  );

  chacc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (wsum),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_idx     <= '0;
      active_flag <= 1'b0;
      tag_count   <= '0;
      sidx        <= '0;
      cmp_vld     <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (clr_idx == BIN_AW'(NUM_BINS - 1)) begin
            clr_idx <= '0;
            state   <= S_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (fill_valid) begin
            op_q     <= op_t'(op);
            bin_q    <= time_bin;
            chg_q    <= charge;
            trk_q    <= has_track;
            id_q     <= track_id;
            r_total  <= '0;
            r_slot   <= '0;
            r_new    <= 1'b0;
            r_full   <= 1'b0;
            r_weight <= '0;
            r_mean   <= '0;
            if (op_t'(op) == OP_CLEAR) begin
              tag_count   <= '0;
              active_flag <= 1'b0;
              state       <= S_OUT;
            end else begin
              active_flag <= 1'b1;
              state       <= S_BRD;
            end
          end
        end
        S_BRD: begin
          state <= S_BADD;
        end
        S_BADD: begin
          r_total <= bin_ok ? bin_sat : '0;
          sidx    <= '0;
          cmp_vld <= 1'b0;
          state   <= trk_q ? S_SRCH : S_OUT;
        end
        S_SRCH: begin
          if (hit) begin
            hit_idx <= cmp_idx;
            w_q     <= tag_rd.weight;
            m_q     <= tag_rd.mean;
            state   <= S_MUL;
          end else if (sidx < tag_count) begin
            cmp_idx <= sidx[TAG_AW-1:0];
            cmp_vld <= 1'b1;
            sidx    <= sidx + 1'b1;
          end else if (cmp_vld) begin
            cmp_vld <= 1'b0;
          end else begin
            if (room) begin
              tag_count <= tag_count + 1'b1;
              r_slot    <= SLOT_W'(tag_count);
              r_new     <= 1'b1;
              r_weight  <= WGT_W'(chg_q);
              r_mean    <= mean_ins;
            end else begin
              r_full    <= 1'b1;
            end
            state <= S_OUT;
          end
        end
        S_MUL: begin
          prod_wm <= w_q * m_q;
          prod_cb <= chg_q * bin_q;
          wsum    <= {1'b0, w_q} + DEN_W'(chg_q);
          state   <= S_DIVS;
        end
        S_DIVS: begin
          state <= (wsum != '0) ? S_DIVW : S_TWR;
        end
        S_DIVW: begin
          if (div_sts.done) begin
            m_q   <= div_quo;
            state <= S_TWR;
          end
        end
        S_TWR: begin
          r_slot   <= SLOT_W'(hit_idx);
          r_weight <= wsat;
          r_mean   <= m_q;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid      <= 1'b1;
            bin_total      <= r_total;
            slot           <= r_slot;
            new_entry      <= r_new;
            table_full     <= r_full;
            track_weight   <= r_weight;
            track_mean_bin <= r_mean;
            state          <= (op_q == OP_CLEAR) ? S_CLR : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CHACC_ASSERT_ALWAYS(a_cnt_range, tag_count <= CNT_W'(NUM_TAGS), "tag count past table")
  `CHACC_ASSERT_ALWAYS(a_tags_active, (tag_count == '0) || active_flag, "tags while inactive")
  `CHACC_ASSERT_IMPLY(a_div_free, div_start, !div_sts.busy && !div_sts.done, "divider busy")
  `CHACC_ASSERT_IMPLY(a_div_done, div_sts.done, state == S_DIVW, "stray divider done")
  `CHACC_ASSERT_NEXT(a_clear, clr_acc, (tag_count == '0) && !active_flag, "clear missed")

endmodule
